@@ hdl/grid3d_neighbor_expansion_assert.svh @@
// Assertion macros shared by the RTL of the grid neighbor expansion block.
`ifndef GRID3D_NEIGHBOR_EXPANSION_ASSERT_SVH
`define GRID3D_NEIGHBOR_EXPANSION_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define GNE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define GNE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define GNE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GNE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/gne_pkg.sv @@
`timescale 1ns / 1ps
package gne_pkg;

  // Fixed field widths.
  localparam int NODE_W     = 12;
  localparam int COST_W     = 16;
  localparam int DIM_W      = 13;
  localparam int TOTAL_W    = 32;
  localparam int SUM_W      = 34;
  localparam int ID_W       = 40;
  localparam int PLANE_W    = 2 * DIM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 4;
  localparam int DIR_W      = 3;

  // Parameter defaults.
  localparam int DEF_MAX_CELLS   = 4096;
  localparam int DEF_WEIGHT_BITS = 16;

  typedef logic [1:0] req_t;

  // Request codes.
  localparam req_t REQ_WRITE  = 2'd0;
  localparam req_t REQ_EXPAND = 2'd1;
  localparam req_t REQ_PATH   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE  = 3'd4;

  // Reset values of the registers.
  localparam logic [DIM_W-1:0]  RST_DIM   = 13'd16;
  localparam logic [COST_W-1:0] RST_PAUSE = 16'd256;

  // Cost added when a path steps onto a blocked cell (-1.0 in Q8.8).
  localparam logic signed [SUM_W-1:0] BLOCKED_ADD = -34'sd256;

  // Direction codes of the six face neighbors, in emit order.
  localparam logic [DIR_W-1:0] DIR_ZM = 3'd0;
  localparam logic [DIR_W-1:0] DIR_ZP = 3'd1;
  localparam logic [DIR_W-1:0] DIR_YM = 3'd2;
  localparam logic [DIR_W-1:0] DIR_YP = 3'd3;
  localparam logic [DIR_W-1:0] DIR_XM = 3'd4;
  localparam logic [DIR_W-1:0] DIR_XP = 3'd5;

endpackage

@@ hdl/grid3d_neighbor_expansion.sv @@
`timescale 1ns / 1ps
// Six-neighbor expansion over a 3D grid of weighted cells.
// Input: a word is taken on a rising edge with start high and busy low. A write
// stores one cell; busy stays low. A path step reads the weight store once and
// gives one result word, computed in the S_PATH state and then registered.
// An expand request decodes the node id with one shared bit-serial divider
// (first for z, then for y and x), then visits the six neighbors, each with an
// address step and then the read data of the single store port. Results appear
// as they are found, each held back one step so that the final one can carry
// last. A blocked or out-of-grid source gives one word with none_found set.
// Output: each result word is on the out_ ports for exactly one cycle with
// out_valid high; the receiver cannot stall, so no backpressure exists.
// Configuration is written through cfg_we, cfg_index and cfg_data, by the user
// only while idle; the block does not enforce this. Reset sets the registers to
// their defaults and clears the path total and the previous node. The weight
// store is not cleared; cells must be written before they are read.
module grid3d_neighbor_expansion
  import gne_pkg::*;
#(
  parameter int MAX_CELLS   = DEF_MAX_CELLS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  req_t                      in_req_type,
  input  logic [NODE_W-1:0]         in_node,
  input  logic [COST_W-1:0]         in_weight_value,
  input  logic                      in_blocked,
  input  logic                      in_reversed,
  input  logic                      in_include_self,
  input  logic                      in_path_first,
  input  logic                      in_path_last,
  output logic                      out_valid,
  output logic [NODE_W-1:0]         out_neighbor_node,
  output logic [COST_W-1:0]         out_edge_cost,
  output logic                      out_none_found,
  output logic signed [TOTAL_W-1:0] out_path_total,
  output logic                      out_last,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

`include "grid3d_neighbor_expansion_assert.svh"

  localparam int AW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int EW  = WEIGHT_BITS + 1;
  localparam int LAST_STEP = NODE_W - 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PLANE = 4'd1;
  localparam logic [3:0] S_DIVZ  = 4'd2;
  localparam logic [3:0] S_DIVY  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_NADDR = 4'd5;
  localparam logic [3:0] S_NDATA = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_PATH  = 4'd8;

  // Configuration registers.
  logic [DIM_W-1:0]  grid_width_r, grid_height_r, grid_depth_r;
  logic              wrap_r;
  logic [COST_W-1:0] pause_r;

  // Weight store.
  logic [EW-1:0] store [MAX_CELLS];
  logic [EW-1:0] rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [EW-1:0] mem_wd;

  // Control and request state.
  logic [3:0]        state_r, state_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic              rev_r, rev_nxt, self_r, self_nxt;
  logic              first_r, first_nxt, plast_r, plast_nxt;
  logic              src_in_r, src_in_nxt;
  logic [EW-1:0]     src_r, src_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [ID_W-1:0]   zspan_r, zspan_nxt;
  logic [NODE_W-1:0] dq_r, dq_nxt, drem_r, drem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NODE_W-1:0] x0_r, x0_nxt, y0_r, y0_nxt, z0_r, z0_nxt;
  logic [DIR_W-1:0]  dir_r, dir_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              ok_r, ok_nxt;

  // Path state.
  logic signed [TOTAL_W-1:0] total_r, total_nxt;
  logic [NODE_W-1:0]         prev_r, prev_nxt;

  // Held-back result and output registers.
  logic              pend_r, pend_nxt;
  logic [NODE_W-1:0] pend_node_r, pend_node_nxt;
  logic [COST_W-1:0] pend_cost_r, pend_cost_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_node_r, out_node_nxt;
  logic [COST_W-1:0] out_cost_r, out_cost_nxt;
  logic              out_none_r, out_none_nxt;
  logic signed [TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic              out_last_r, out_last_nxt;

  // Combinational helpers.
  logic              accept;
  logic [DIM_W-1:0]  w_eff, h_eff, d_eff;
  logic [PLANE_W-1:0] divisor;
  logic [NODE_W:0]   trial;
  logic              ge;
  logic [NODE_W-1:0] q_step, r_step;
  logic [ID_W-1:0]   node_w, plane_w, width_w, cand_id;
  logic              at_edge, cand_ok;
  logic              produce;
  logic [NODE_W-1:0] prod_node;
  logic [COST_W-1:0] prod_cost;
  logic signed [SUM_W-1:0] add_val, sum_val;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // A size register of zero behaves as one.
  assign w_eff = (grid_width_r  == '0) ? DIM_W'(1) : grid_width_r;
  assign h_eff = (grid_height_r == '0) ? DIM_W'(1) : grid_height_r;
  assign d_eff = (grid_depth_r  == '0) ? DIM_W'(1) : grid_depth_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= RST_DIM;
      grid_height_r <= RST_DIM;
      grid_depth_r  <= RST_DIM;
      wrap_r        <= 1'b0;
      pause_r       <= RST_PAUSE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  grid_width_r  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: grid_height_r <= cfg_data[DIM_W-1:0];
        CFG_DEPTH:  grid_depth_r  <= cfg_data[DIM_W-1:0];
        CFG_WRAP:   wrap_r        <= cfg_data[0];
        CFG_PAUSE:  pause_r       <= cfg_data[COST_W-1:0];
        default: ;
      endcase
    end
  end

  // Weight store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_wa] <= mem_wd;
    end
    rd_data_r <= store[mem_ra];
  end

  assign mem_we = accept && (in_req_type == REQ_WRITE) &&
                  (ID_W'(in_node) < ID_W'(MAX_CELLS));
  assign mem_wa = AW'(in_node);
  assign mem_wd = {in_blocked, WEIGHT_BITS'(in_weight_value)};
  assign mem_ra = (state_r == S_NADDR) ? AW'(cand_id) : AW'(in_node);

  // One restoring divider step; the divisor is the plane size, then the width.
  assign divisor = (state_r == S_DIVZ) ? plane_r : PLANE_W'(w_eff);
  assign trial   = {drem_r, dq_r[NODE_W-1]};
  assign ge      = PLANE_W'(trial) >= divisor;
  assign q_step  = {dq_r[NODE_W-2:0], ge};
  assign r_step  = ge ? NODE_W'(PLANE_W'(trial) - divisor) : trial[NODE_W-1:0];

  // Neighbor id for the current direction, wrapped or flagged at the border.
  assign node_w  = ID_W'(node_r);
  assign plane_w = ID_W'(plane_r);
  assign width_w = ID_W'(w_eff);
  always_comb begin
    at_edge = 1'b0;
    cand_id = node_w;
    unique case (dir_r)
      DIR_ZM: begin
        at_edge = (z0_r == '0);
        cand_id = at_edge ? node_w + zspan_r : node_w - plane_w;
      end
      DIR_ZP: begin
        at_edge = (DIM_W'(z0_r) == d_eff - DIM_W'(1));
        cand_id = at_edge ? node_w - zspan_r : node_w + plane_w;
      end
      DIR_YM: begin
        at_edge = (y0_r == '0);
        cand_id = at_edge ? node_w + plane_w - width_w : node_w - width_w;
      end
      DIR_YP: begin
        at_edge = (DIM_W'(y0_r) == h_eff - DIM_W'(1));
        cand_id = at_edge ? node_w - plane_w + width_w : node_w + width_w;
      end
      DIR_XM: begin
        at_edge = (x0_r == '0);
        cand_id = at_edge ? node_w + width_w - ID_W'(1) : node_w - ID_W'(1);
      end
      DIR_XP: begin
        at_edge = (DIM_W'(x0_r) == w_eff - DIM_W'(1));
        cand_id = at_edge ? node_w - width_w + ID_W'(1) : node_w + ID_W'(1);
      end
      default: ;
    endcase
    cand_ok = (!at_edge || wrap_r) && (cand_id < ID_W'(MAX_CELLS));
  end

  // Path cost: pause on the same node, -1.0 on a blocked or out-of-range cell, else the weight.
  always_comb begin
    if (node_r == prev_r) begin
      add_val = SUM_W'(pause_r);
    end else if (!src_in_r || rd_data_r[WEIGHT_BITS]) begin
      add_val = BLOCKED_ADD;
    end else begin
      add_val = SUM_W'(rd_data_r[WEIGHT_BITS-1:0]);
    end
    sum_val = SUM_W'(total_r) + add_val;
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    rev_nxt       = rev_r;
    self_nxt      = self_r;
    first_nxt     = first_r;
    plast_nxt     = plast_r;
    src_in_nxt    = src_in_r;
    src_nxt       = src_r;
    plane_nxt     = plane_r;
    zspan_nxt     = zspan_r;
    dq_nxt        = dq_r;
    drem_nxt      = drem_r;
    cnt_nxt       = cnt_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    z0_nxt        = z0_r;
    dir_nxt       = dir_r;
    id_nxt        = id_r;
    ok_nxt        = ok_r;
    total_nxt     = total_r;
    prev_nxt      = prev_r;
    pend_nxt      = pend_r;
    pend_node_nxt = pend_node_r;
    pend_cost_nxt = pend_cost_r;
    out_valid_nxt = 1'b0;
    out_node_nxt  = out_node_r;
    out_cost_nxt  = out_cost_r;
    out_none_nxt  = out_none_r;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;
    produce       = 1'b0;
    prod_node     = node_r;
    prod_cost     = pause_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          node_nxt   = in_node;
          rev_nxt    = in_reversed;
          self_nxt   = in_include_self;
          first_nxt  = in_path_first;
          plast_nxt  = in_path_last;
          src_in_nxt = ID_W'(in_node) < ID_W'(MAX_CELLS);
          if (in_req_type == REQ_EXPAND) begin
            state_nxt = S_PLANE;
          end else if (in_req_type == REQ_PATH) begin
            state_nxt = S_PATH;
          end
        end
      end
      S_PLANE: begin
        src_nxt   = rd_data_r;
        plane_nxt = PLANE_W'(w_eff) * PLANE_W'(h_eff);
        dq_nxt    = node_r;
        drem_nxt  = '0;
        cnt_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_DIVZ;
      end
      S_DIVZ: begin
        zspan_nxt = ID_W'(d_eff - DIM_W'(1)) * plane_w;
        if (cnt_r == CNT_W'(LAST_STEP)) begin
          z0_nxt    = q_step;
          dq_nxt    = r_step;
          drem_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIVY;
        end else begin
          dq_nxt   = q_step;
          drem_nxt = r_step;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      S_DIVY: begin
        if (cnt_r == CNT_W'(LAST_STEP)) begin
          y0_nxt    = q_step;
          x0_nxt    = r_step;
          state_nxt = S_CHECK;
        end else begin
          dq_nxt   = q_step;
          drem_nxt = r_step;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      S_CHECK: begin
        dir_nxt = DIR_ZM;
        if ((DIM_W'(z0_r) >= d_eff) || !src_in_r || src_r[WEIGHT_BITS]) begin
          state_nxt = S_FIN;
        end else begin
          produce   = self_r;
          state_nxt = S_NADDR;
        end
      end
      S_NADDR: begin
        id_nxt    = cand_id;
        ok_nxt    = cand_ok;
        state_nxt = S_NDATA;
      end
      S_NDATA: begin
        produce   = ok_r && !rd_data_r[WEIGHT_BITS];
        prod_node = id_r[NODE_W-1:0];
        prod_cost = rev_r ? COST_W'(src_r[WEIGHT_BITS-1:0])
                          : COST_W'(rd_data_r[WEIGHT_BITS-1:0]);
        if (dir_r == DIR_XP) begin
          state_nxt = S_FIN;
        end else begin
          dir_nxt   = dir_r + DIR_W'(1);
          state_nxt = S_NADDR;
        end
      end
      S_FIN: begin
        // Release the held word as final, or report an empty expansion.
        out_valid_nxt = 1'b1;
        out_node_nxt  = pend_r ? pend_node_r : '0;
        out_cost_nxt  = pend_r ? pend_cost_r : '0;
        out_none_nxt  = !pend_r;
        out_total_nxt = '0;
        out_last_nxt  = 1'b1;
        pend_nxt      = 1'b0;
        state_nxt     = S_IDLE;
      end
      S_PATH: begin
        if (first_r) begin
          total_nxt = '0;
        end else if (sum_val > SUM_W'(32'sh7FFF_FFFF)) begin
          total_nxt = 32'sh7FFF_FFFF;
        end else if (sum_val < -SUM_W'(33'sh0_8000_0000)) begin
          total_nxt = 32'sh8000_0000;
        end else begin
          total_nxt = TOTAL_W'(sum_val);
        end
        prev_nxt      = node_r;
        out_valid_nxt = 1'b1;
        out_node_nxt  = node_r;
        out_cost_nxt  = '0;
        out_none_nxt  = 1'b0;
        out_total_nxt = total_nxt;
        out_last_nxt  = plast_r;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // A new word pushes the held one out, not yet final.
    if (produce) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_node_nxt  = pend_node_r;
        out_cost_nxt  = pend_cost_r;
        out_none_nxt  = 1'b0;
        out_total_nxt = '0;
        out_last_nxt  = 1'b0;
      end
      pend_nxt      = 1'b1;
      pend_node_nxt = prod_node;
      pend_cost_nxt = prod_cost;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      prev_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      prev_r      <= prev_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    rev_r       <= rev_nxt;
    self_r      <= self_nxt;
    first_r     <= first_nxt;
    plast_r     <= plast_nxt;
    src_in_r    <= src_in_nxt;
    src_r       <= src_nxt;
    plane_r     <= plane_nxt;
    zspan_r     <= zspan_nxt;
    dq_r        <= dq_nxt;
    drem_r      <= drem_nxt;
    cnt_r       <= cnt_nxt;
    x0_r        <= x0_nxt;
    y0_r        <= y0_nxt;
    z0_r        <= z0_nxt;
    dir_r       <= dir_nxt;
    id_r        <= id_nxt;
    ok_r        <= ok_nxt;
    pend_node_r <= pend_node_nxt;
    pend_cost_r <= pend_cost_nxt;
    out_node_r  <= out_node_nxt;
    out_cost_r  <= out_cost_nxt;
    out_none_r  <= out_none_nxt;
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_neighbor_node = out_node_r;
  assign out_edge_cost     = out_cost_r;
  assign out_none_found    = out_none_r;
  assign out_path_total    = out_total_r;
  assign out_last          = out_last_r;

  // Checks on the sequencer and the held-back word.
  `GNE_ASSERT_IMP(a_no_out_in_divide, clk, rst_n,
    (state_r == S_DIVZ) || (state_r == S_DIVY), !out_valid_r)
  `GNE_ASSERT_IMP(a_none_is_last, clk, rst_n, out_valid_r && out_none_r, out_last_r)
  `GNE_ASSERT_NXT(a_fin_emits_last, clk, rst_n, state_r == S_FIN,
    out_valid_r && out_last_r && !pend_r)
  `GNE_ASSERT_NXT(a_expand_starts, clk, rst_n, accept && (in_req_type == REQ_EXPAND),
    state_r == S_PLANE)

endmodule
